FILE: rtl/core/mtcqf_pkg.sv
// Package for the MTC quarter-frame decoder: widths, constants, types and helpers.
`default_nettype none
package mtcqf_pkg;

  localparam int BYTE_W   = 8;
  localparam int FRAMES_W = 5;
  localparam int SECS_W   = 6;
  localparam int MINS_W   = 6;
  localparam int HOURS_W  = 5;
  localparam int CODE_W   = 2;
  localparam int SR_W     = 18;
  localparam int POS_W    = 35;
  localparam int WHOLE_W  = 17;  // h*3600 + m*60 + s, max 115443
  localparam int DIVD_W   = 23;  // frames * sample_rate, max 31 * (2^18 - 1)
  localparam int RDIV_W   = 5;   // frame rate divisor, at most 30
  localparam int CNT_W    = 5;
  localparam int CFG_IDX_W = 1;

  localparam logic [WHOLE_W-1:0] HOUR_SECS = WHOLE_W'(3600);
  localparam logic [WHOLE_W-1:0] MIN_SECS  = WHOLE_W'(60);

  localparam logic [CNT_W-1:0] MUL_STEPS = CNT_W'(SR_W);
  localparam logic [CNT_W-1:0] DIV_STEPS = CNT_W'(DIVD_W);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_EN     = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_RATE = 1'b1;

  localparam logic [SR_W-1:0] SAMPLE_RATE_RST = SR_W'(48000);

  // Quarter-frame piece numbers
  localparam logic [2:0] PC_FRAMES_LO = 3'd0;
  localparam logic [2:0] PC_FRAMES_HI = 3'd1;
  localparam logic [2:0] PC_SECS_LO   = 3'd2;
  localparam logic [2:0] PC_SECS_HI   = 3'd3;
  localparam logic [2:0] PC_MINS_LO   = 3'd4;
  localparam logic [2:0] PC_MINS_HI   = 3'd5;
  localparam logic [2:0] PC_HOURS_LO  = 3'd6;
  localparam logic [2:0] PC_HOURS_HI  = 3'd7;

  // Frame rate codes
  localparam logic [CODE_W-1:0] RATE_24 = 2'd0;
  localparam logic [CODE_W-1:0] RATE_25 = 2'd1;
  localparam logic [CODE_W-1:0] RATE_29 = 2'd2;
  localparam logic [CODE_W-1:0] RATE_30 = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_MUL,
    ST_DIV,
    ST_FIN,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic ready;
    logic load;
    logic mul;
    logic div;
    logic fin;
    logic valid;
  } ctl_t;

  function automatic logic [RDIV_W-1:0] rate_div(input logic [CODE_W-1:0] code);
    logic [RDIV_W-1:0] r;
    unique case (code)
      RATE_24: r = RDIV_W'(24);
      RATE_25: r = RDIV_W'(25);
      RATE_29: r = RDIV_W'(29);
      RATE_30: r = RDIV_W'(30);
      default: r = RDIV_W'(30);
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/mtcqf_if.sv
// Valid/ready channel interfaces for quarter-frame bytes and decoded results.
`default_nettype none
interface mtcqf_in_if;
  import mtcqf_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] qf_byte;
  modport source (output valid, output qf_byte, input ready);
  modport sink   (input valid, input qf_byte, output ready);
endinterface

interface mtcqf_out_if;
  import mtcqf_pkg::*;
  logic                valid;
  logic                ready;
  logic [POS_W-1:0]    position_samples;
  logic [HOURS_W-1:0]  tc_hours;
  logic [MINS_W-1:0]   tc_minutes;
  logic [SECS_W-1:0]   tc_seconds;
  logic [FRAMES_W-1:0] tc_frames;
  logic [CODE_W-1:0]   rate_code;
  modport source (output valid, output position_samples, output tc_hours,
                  output tc_minutes, output tc_seconds, output tc_frames,
                  output rate_code, input ready);
  modport sink   (input valid, input position_samples, input tc_hours,
                  input tc_minutes, input tc_seconds, input tc_frames,
                  input rate_code, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/mtcqf_alu.sv
// Shared adder/subtractor used for multiply, divide and final sum steps.
`default_nettype none
module mtcqf_alu (
  input  wire logic                      sub,
  input  wire logic [mtcqf_pkg::POS_W-1:0] a,
  input  wire logic [mtcqf_pkg::POS_W-1:0] b,
  output logic      [mtcqf_pkg::POS_W-1:0] res,
  output logic                           borrow
);
  import mtcqf_pkg::*;

  logic [POS_W:0] full;

  always_comb begin
    if (sub) begin
      full = {1'b0, a} - {1'b0, b};
    end else begin
      full = {1'b0, a} + {1'b0, b};
    end
  end

  assign res    = full[POS_W-1:0];
  assign borrow = sub & full[POS_W];

endmodule
`default_nettype wire

FILE: rtl/core/mtcqf_ctrl.sv
// Sequencer: load, shift-add multiply, restoring divide, final add, result hold.
`default_nettype none
module mtcqf_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  input  wire logic           out_ready,
  output mtcqf_pkg::ctl_t     ctl
);
  import mtcqf_pkg::*;

  state_t           state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    unique case (state)
      ST_IDLE: begin
        if (start) state_next = ST_LOAD;
      end
      ST_LOAD: begin
        state_next = ST_MUL;
        cnt_next   = MUL_STEPS - CNT_W'(1);
      end
      ST_MUL: begin
        if (cnt == '0) begin
          state_next = ST_DIV;
          cnt_next   = DIV_STEPS - CNT_W'(1);
        end else begin
          cnt_next = cnt - CNT_W'(1);
        end
      end
      ST_DIV: begin
        if (cnt == '0) begin
          state_next = ST_FIN;
        end else begin
          cnt_next = cnt - CNT_W'(1);
        end
      end
      ST_FIN: begin
        state_next = ST_OUT;
      end
      ST_OUT: begin
        if (out_ready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl = '0;
    unique case (state)
      ST_IDLE: ctl.ready = 1'b1;
      ST_LOAD: ctl.load  = 1'b1;
      ST_MUL:  ctl.mul   = 1'b1;
      ST_DIV:  ctl.div   = 1'b1;
      ST_FIN:  ctl.fin   = 1'b1;
      ST_OUT:  ctl.valid = 1'b1;
      default: ctl = '0;
    endcase
  end

endmodule
`default_nettype wire

FILE: rtl/core/mtc_quarter_frame_decoder.sv
// MTC quarter-frame decoder: timecode assembly and conversion to sample position.
// With sync on, pieces 0..6 are stored and give no result; a piece-7 byte gives
// its result after a load, 18 multiply and 23 divide steps and a final add, all
// through one shared 35-bit adder. The next byte is taken the cycle after the
// result transaction, so no byte is taken while a piece-7 byte is converted or
// while its result waits at the output.
// Reset (synchronous, active high): time fields cleared, sync off, rate 48000.
`default_nettype none
module mtc_quarter_frame_decoder (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            wr_en,
  input  wire logic [mtcqf_pkg::CFG_IDX_W-1:0] wr_index,
  input  wire logic [mtcqf_pkg::SR_W-1:0]      wr_data,
  mtcqf_in_if.sink                             qf,
  mtcqf_out_if.source                          res
);
  import mtcqf_pkg::*;

  logic                sync_en;
  logic [SR_W-1:0]     sample_rate;
  logic [FRAMES_W-1:0] frames_acc;
  logic [SECS_W-1:0]   seconds_acc;
  logic [MINS_W-1:0]   minutes_acc;
  logic [HOURS_W-1:0]  hours_acc;
  logic [CODE_W-1:0]   rate_code;
  logic [RDIV_W-1:0]   rdiv;

  logic [POS_W-1:0]    mcand;
  logic [SR_W-1:0]     mplier;
  logic [POS_W-1:0]    acc;
  logic [DIVD_W-1:0]   divd;   // dividend shifts out, quotient shifts in
  logic [RDIV_W-1:0]   rem;

  ctl_t                ctl;
  logic                take;
  logic [2:0]          piece;
  logic [3:0]          nib;
  logic                start;

  logic                alu_sub;
  logic [POS_W-1:0]    alu_a, alu_b, alu_res;
  logic                alu_borrow;
  logic [RDIV_W:0]     trial;
  logic [WHOLE_W-1:0]  whole;

  assign take  = qf.valid & ctl.ready;
  assign piece = qf.qf_byte[6:4];
  assign nib   = qf.qf_byte[3:0];
  assign start = take & sync_en & (piece == PC_HOURS_HI);

  mtcqf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .out_ready (res.ready),
    .ctl       (ctl)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      sync_en     <= 1'b0;
      sample_rate <= SAMPLE_RATE_RST;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_SYNC_EN:     sync_en     <= wr_data[0];
        REG_SAMPLE_RATE: sample_rate <= wr_data;
        default:         sync_en     <= sync_en;
      endcase
    end
  end

  // timecode assembly
  always_ff @(posedge clk) begin
    if (rst) begin
      frames_acc  <= '0;
      seconds_acc <= '0;
      minutes_acc <= '0;
      hours_acc   <= '0;
    end else if (take && sync_en) begin
      unique case (piece)
        PC_FRAMES_LO: frames_acc  <= {frames_acc[4], nib};
        PC_FRAMES_HI: frames_acc  <= {nib[0], frames_acc[3:0]};
        PC_SECS_LO:   seconds_acc <= {seconds_acc[5:4], nib};
        PC_SECS_HI:   seconds_acc <= {nib[1:0], seconds_acc[3:0]};
        PC_MINS_LO:   minutes_acc <= {minutes_acc[5:4], nib};
        PC_MINS_HI:   minutes_acc <= {nib[1:0], minutes_acc[3:0]};
        PC_HOURS_LO:  hours_acc   <= {hours_acc[4], nib};
        PC_HOURS_HI:  hours_acc   <= {nib[0], hours_acc[3:0]};
        default:      hours_acc   <= hours_acc;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rate_code <= nib[2:1];
      rdiv      <= rate_div(nib[2:1]);
    end
  end

  assign whole = WHOLE_W'(hours_acc) * HOUR_SECS + WHOLE_W'(minutes_acc) * MIN_SECS
               + WHOLE_W'(seconds_acc);

  // divide step: bring down the next dividend bit
  assign trial = {rem, divd[DIVD_W-1]};

  always_comb begin
    alu_sub = 1'b0;
    alu_a   = acc;
    alu_b   = mcand;
    if (ctl.div) begin
      alu_sub = 1'b1;
      alu_a   = POS_W'(trial);
      alu_b   = POS_W'(rdiv);
    end else if (ctl.fin) begin
      alu_b   = POS_W'(divd);
    end
  end

  mtcqf_alu u_alu (
    .sub    (alu_sub),
    .a      (alu_a),
    .b      (alu_b),
    .res    (alu_res),
    .borrow (alu_borrow)
  );

  // position = whole * rate + floor(frames * rate / divisor)
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      mcand  <= POS_W'(whole);
      mplier <= sample_rate;
      acc    <= '0;
      divd   <= DIVD_W'(frames_acc) * DIVD_W'(sample_rate);
      rem    <= '0;
    end else if (ctl.mul) begin
      if (mplier[0]) acc <= alu_res;
      mcand  <= {mcand[POS_W-2:0], 1'b0};
      mplier <= {1'b0, mplier[SR_W-1:1]};
    end else if (ctl.div) begin
      if (!alu_borrow) begin
        rem  <= alu_res[RDIV_W-1:0];
        divd <= {divd[DIVD_W-2:0], 1'b1};
      end else begin
        rem  <= trial[RDIV_W-1:0];
        divd <= {divd[DIVD_W-2:0], 1'b0};
      end
    end else if (ctl.fin) begin
      acc <= alu_res;
    end
  end

  assign qf.ready             = ctl.ready;
  assign res.valid            = ctl.valid;
  assign res.position_samples = acc;
  assign res.tc_hours         = hours_acc;
  assign res.tc_minutes       = minutes_acc;
  assign res.tc_seconds       = seconds_acc;
  assign res.tc_frames        = frames_acc;
  assign res.rate_code        = rate_code;

endmodule
`default_nettype wire

FILE: rtl/core/mtcqf_checker.sv
// Port-level checks for the MTC quarter-frame decoder, bound to the top level.
`default_nettype none
module mtcqf_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          in_valid,
  input wire logic                          in_ready,
  input wire logic [mtcqf_pkg::BYTE_W-1:0]  in_byte,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic [mtcqf_pkg::POS_W-1:0]   out_pos,
  input wire logic [mtcqf_pkg::CODE_W-1:0]  out_code
);
  import mtcqf_pkg::*;

  // byte intake is stalled while a result is pending
  a_busy_while_result: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready)
    else $error("input ready while result pending");

  // a non-final piece leaves the decoder idle, with no result, in the next cycle
  a_short_piece: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && in_byte[6:4] != PC_HOURS_HI) |=> (in_ready && !out_valid))
    else $error("non-final piece did not return to idle");

  // a result never appears straight after a byte transaction
  a_no_early_result: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !out_valid)
    else $error("result too soon after byte transaction");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_pos) && $stable(out_code)))
    else $error("stalled result changed");

  a_reset_clear: assert property (@(posedge clk)
    rst |=> (!out_valid && in_ready))
    else $error("result or busy after reset");

endmodule

bind mtc_quarter_frame_decoder mtcqf_checker u_mtcqf_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (qf.valid),
  .in_ready  (qf.ready),
  .in_byte   (qf.qf_byte),
  .out_valid (res.valid),
  .out_ready (res.ready),
  .out_pos   (res.position_samples),
  .out_code  (res.rate_code)
);
`default_nettype wire
